[sv/bmag_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmag_pkg
// Shared constants, types and helpers for the broadcast multiply address
// generator.
// ----------------------------------------------------------------------------
package bmag_pkg;

    localparam int MAX_DIMS  = 4;
    localparam int SIZE_BITS = 8;

    localparam int IDX_W    = 32;
    localparam int CFG_W    = 32;
    localparam int NDIM_W   = 3;
    localparam int MASK_W   = 4;
    localparam int REGIDX_W = 2;

    // Cycles needed by the stride chain to settle after a configuration write.
    localparam int SETTLE_W = $clog2(MAX_DIMS + 1);
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(MAX_DIMS - 1);

    typedef logic [SIZE_BITS-1:0] digit_t;
    typedef logic [IDX_W-1:0]     index_t;

    typedef enum logic [REGIDX_W-1:0] {
        REG_NUM_DIMS    = 2'd0,
        REG_OUT_SIZES   = 2'd1,
        REG_X_SPAN_MASK = 2'd2,
        REG_Y_SPAN_MASK = 2'd3
    } cfg_reg_t;

    // Size of one dimension; a zero field or one lying above the register
    // counts as size one.
    function automatic digit_t dim_size(input logic [CFG_W-1:0] sizes, input int d);
        logic [CFG_W-1:0] shifted;
        digit_t           field;
        shifted = '0;
        if (d * SIZE_BITS < CFG_W) begin
            shifted = sizes >> (d * SIZE_BITS);
        end
        field = shifted[SIZE_BITS-1:0];
        return (field == '0) ? digit_t'(1) : field;
    endfunction

    // Span bit of one dimension; dimensions beyond the mask never span.
    function automatic logic spans(input logic [MASK_W-1:0] mask, input int d);
        logic bit_val;
        bit_val = 1'b0;
        if (d < MASK_W) begin
            bit_val = mask[d];
        end
        return bit_val;
    endfunction

endpackage

[sv/broadcast_multiply_address_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_multiply_address_generator_core
// Walks an N-dimensional output array in column-major order and gives, for
// each request word, the linear output index and the matching x and y indices
// of a broadcast multiply.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Contents
//  --------  ---------  --------------------  ----------------------------------
//  s_        in         s_tvalid / s_tready   tdata[0] restart
//  m_        out        m_tvalid / m_tready   tdata out, x, y index; tlast last
//  cfg_      in         cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// One request word is taken per cycle while s_tready is high, and its address
// word appears in the output register in the cycle after it is taken; the walk
// state and result come from a single layer of compare, select and add logic.
// After reset, and after every configuration write, the request side is held
// off by a settling counter while the stride chain, one multiplier per dimension
// above dimension 0 for each of x and y, settles.
// The output register is the only stage: once the stride chain has settled, a
// new request is taken whenever the register is empty or is being emptied in
// the same cycle, so a stalled downstream side stalls only the request side.
// The configuration port is always ready.
//
module broadcast_multiply_address_generator_core
    import bmag_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [0] restart, [7:1] zero

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [3*IDX_W-1:0]   m_tdata,    // [31:0] out_index, [63:32] x_index,
                                             // [95:64] y_index
    output logic                 m_tlast,    // last element of the array

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REGIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [NDIM_W-1:0] num_dims_reg;
    logic [CFG_W-1:0]  out_sizes_reg;
    logic [MASK_W-1:0] x_span_mask_reg;
    logic [MASK_W-1:0] y_span_mask_reg;

    // Settling counter for the stride chain.
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;

    // Stride of each dimension within x and y: the product of the spanned
    // sizes of all lower dimensions.
    index_t x_stride_reg [MAX_DIMS];
    index_t y_stride_reg [MAX_DIMS];

    // Walk state.
    digit_t digit_reg  [MAX_DIMS];
    digit_t digit_next [MAX_DIMS];
    index_t x_offset_reg, x_offset_next;
    index_t y_offset_reg, y_offset_next;
    index_t out_pos_reg,  out_pos_next;

    // Output register.
    logic               m_tvalid_reg;
    logic [3*IDX_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    logic   s_accept;
    logic   cfg_accept;
    logic   restart;
    logic   is_last;
    index_t x_cur, y_cur, pos_cur;
    index_t x_rewind, y_rewind;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign s_tready = (settle_reg == '0) && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign restart  = s_tdata[0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Configuration and stride chain
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg    <= NDIM_W'(1);
            out_sizes_reg   <= 32'h0101_0101;
            x_span_mask_reg <= '1;
            y_span_mask_reg <= '1;
        end else if (cfg_accept) begin
            case (cfg_reg_t'(cfg_index))
                REG_NUM_DIMS:    num_dims_reg    <= cfg_data[NDIM_W-1:0];
                REG_OUT_SIZES:   out_sizes_reg   <= cfg_data;
                REG_X_SPAN_MASK: x_span_mask_reg <= cfg_data[MASK_W-1:0];
                REG_Y_SPAN_MASK: y_span_mask_reg <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        settle_next = settle_reg;
        if (cfg_accept) begin
            settle_next = SETTLE_CYCLES;
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - SETTLE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
        end else begin
            settle_reg <= settle_next;
        end
    end

    // Each stage multiplies the stride below it by the lower dimension's size if
    // the operand spans it, else passes it on; changes ripple up stage by stage.
    always_ff @(posedge aclk) begin
        x_stride_reg[0] <= IDX_W'(1);
        y_stride_reg[0] <= IDX_W'(1);
        for (int d = 1; d < MAX_DIMS; d++) begin
            x_stride_reg[d] <= spans(x_span_mask_reg, d - 1)
                ? IDX_W'(x_stride_reg[d-1] * IDX_W'(dim_size(out_sizes_reg, d - 1)))
                : x_stride_reg[d-1];
            y_stride_reg[d] <= spans(y_span_mask_reg, d - 1)
                ? IDX_W'(y_stride_reg[d-1] * IDX_W'(dim_size(out_sizes_reg, d - 1)))
                : y_stride_reg[d-1];
        end
    end

    // ------------------------------------------------------------------
    // Odometer step
    // ------------------------------------------------------------------
    // The first active dimension whose digit is not yet final is the one that
    // counts up; all below it wrap. Rewinding the wrapped dimensions and
    // stepping the carry dimension telescopes to +1 when the operand spans the
    // carry dimension, and to 1 - stride otherwise.
    always_comb begin
        digit_t cur     [MAX_DIMS];
        logic   active  [MAX_DIMS];
        logic   at_end  [MAX_DIMS];
        logic   below   [MAX_DIMS];
        logic   carry   [MAX_DIMS];
        logic   all_end;

        x_cur   = restart ? '0 : x_offset_reg;
        y_cur   = restart ? '0 : y_offset_reg;
        pos_cur = restart ? '0 : out_pos_reg;

        all_end  = 1'b1;
        x_rewind = '0;
        y_rewind = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            cur[d]    = restart ? '0 : digit_reg[d];
            active[d] = (d == 0) || ({1'b0, num_dims_reg} > 4'(d));
            at_end[d] = cur[d] >= (dim_size(out_sizes_reg, d) - digit_t'(1));
            below[d]  = all_end;
            carry[d]  = below[d] && active[d] && !at_end[d];
            all_end   = all_end && (at_end[d] || !active[d]);
            if (carry[d] && !spans(x_span_mask_reg, d)) begin
                x_rewind = x_rewind | x_stride_reg[d];
            end
            if (carry[d] && !spans(y_span_mask_reg, d)) begin
                y_rewind = y_rewind | y_stride_reg[d];
            end
        end
        is_last = all_end;

        for (int d = 0; d < MAX_DIMS; d++) begin
            if (is_last || (below[d] && at_end[d])) begin
                digit_next[d] = '0;
            end else if (carry[d]) begin
                digit_next[d] = cur[d] + digit_t'(1);
            end else begin
                digit_next[d] = cur[d];
            end
        end

        x_offset_next = is_last ? '0 : x_cur + IDX_W'(1) - x_rewind;
        y_offset_next = is_last ? '0 : y_cur + IDX_W'(1) - y_rewind;
        out_pos_next  = is_last ? '0 : pos_cur + IDX_W'(1);

        m_tdata_next = {y_cur, x_cur, pos_cur};
        m_tlast_next = is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                digit_reg[d] <= '0;
            end
            x_offset_reg <= '0;
            y_offset_reg <= '0;
            out_pos_reg  <= '0;
        end else if (s_accept) begin
            digit_reg    <= digit_next;
            x_offset_reg <= x_offset_next;
            y_offset_reg <= y_offset_next;
            out_pos_reg  <= out_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

endmodule
